@@ src/kcvp_pkg.sv @@
`default_nettype none
package kcvp_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_ACCEL_VAR    = 3'd0;
   localparam logic [2:0] CSR_INIT_POS_VAR = 3'd1;
   localparam logic [2:0] CSR_INIT_VEL_VAR = 3'd2;
   localparam logic [2:0] CSR_INIT_VX      = 3'd3;
   localparam logic [2:0] CSR_INIT_VY      = 3'd4;

   // sequencer steps: one multiply-round-accumulate-saturate each
   localparam logic [4:0] ST_H   = 5'd0;
   localparam logic [4:0] ST_QH  = 5'd1;
   localparam logic [4:0] ST_QD  = 5'd2;
   localparam logic [4:0] ST_N00 = 5'd3;
   localparam logic [4:0] ST_N02 = 5'd4;
   localparam logic [4:0] ST_N22 = 5'd5;
   localparam logic [4:0] ST_A00 = 5'd6;
   localparam logic [4:0] ST_A01 = 5'd7;
   localparam logic [4:0] ST_A02 = 5'd8;
   localparam logic [4:0] ST_A03 = 5'd9;
   localparam logic [4:0] ST_A10 = 5'd10;
   localparam logic [4:0] ST_A11 = 5'd11;
   localparam logic [4:0] ST_A12 = 5'd12;
   localparam logic [4:0] ST_A13 = 5'd13;
   localparam logic [4:0] ST_P00 = 5'd14;
   localparam logic [4:0] ST_P01 = 5'd15;
   localparam logic [4:0] ST_P02 = 5'd16;
   localparam logic [4:0] ST_P03 = 5'd17;
   localparam logic [4:0] ST_P11 = 5'd18;
   localparam logic [4:0] ST_P12 = 5'd19;
   localparam logic [4:0] ST_P13 = 5'd20;
   localparam logic [4:0] ST_P22 = 5'd21;
   localparam logic [4:0] ST_P23 = 5'd22;
   localparam logic [4:0] ST_P33 = 5'd23;
   localparam logic [4:0] ST_X   = 5'd24;
   localparam logic [4:0] ST_Y   = 5'd25;
   localparam logic [4:0] ST_LAST = ST_Y;

   typedef logic signed [31:0] q32_type;
   typedef logic signed [32:0] opnd_type;

endpackage
`default_nettype wire

@@ src/kalman_cv_predict_2d_unit.sv @@
// Prediction step of a 2-D constant-velocity Kalman filter, signed fixed point.
// Input channel req_: one transfer is one prediction tick carrying dt.
// Result channel rsp_: one transfer per tick with the state and the position
// covariance after the tick, plus a flag set when any value saturated.
// Configuration: csr_we writes csr_wdata into register csr_index; only write
// while the block is idle. Initial values are used on the first tick only.
// One tick takes 26 steps of a single shared 33x33 multiplier followed by a
// round/add/saturate stage, each step a multiply state then an accumulate
// state; a finish state then loads the result. req_stall is high until idle.
// The result sits in an output register; the block takes the next tick while
// it waits, and only holds the following result if the receiver still stalls.
// Reset (synchronous) clears the initialised flag, the registers to their
// defaults and the handshake state.
`default_nettype none
module kalman_cv_predict_2d_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [23:0]        req_dt,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic signed [31:0] rsp_pos_x,
   output      logic signed [31:0] rsp_pos_y,
   output      logic signed [31:0] rsp_vel_x,
   output      logic signed [31:0] rsp_vel_y,
   output      logic signed [31:0] rsp_var_x,
   output      logic signed [31:0] rsp_cov_xy,
   output      logic signed [31:0] rsp_var_y,
   output      logic               rsp_overflow,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_ACC  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   // default initial velocity rescaled to the fraction width
   localparam int UP_SH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int DN_SH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam longint INIT_V_L = ((64'sd231705 <<< UP_SH) + ((64'sd1 <<< DN_SH) >>> 1))
                                 >>> DN_SH;
   localparam logic [31:0] INIT_V = INIT_V_L[31:0];
   localparam logic signed [63:0] HALF_LO = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] HALF_HI = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] MAX32 = 64'sd2147483647;
   localparam logic signed [63:0] MIN32 = -64'sd2147483648;

   logic [1:0]  state_ff;
   logic [4:0]  step_ff;
   logic        init_ff;
   logic        ov_ff;
   logic [23:0] dt_ff;

   logic [30:0] accel_var_ff, init_pos_var_ff, init_vel_var_ff;
   logic [31:0] init_vx_ff, init_vy_ff;

   kcvp_pkg::q32_type c_ff [10];
   kcvp_pkg::q32_type a_ff [8];
   kcvp_pkg::q32_type sv_ff [4];
   kcvp_pkg::q32_type h_ff, qh_ff, qd_ff, n00_ff, n02_ff, n22_ff;

   logic signed [63:0] prod_ff;

   logic               rsp_valid_ff, rsp_ov_ff;
   kcvp_pkg::q32_type  rsp_px_ff, rsp_py_ff, rsp_vx_ff, rsp_vy_ff;
   kcvp_pkg::q32_type  rsp_vxx_ff, rsp_cxy_ff, rsp_vyy_ff;

   kcvp_pkg::opnd_type op_a_in, op_b_in, dt_op;
   kcvp_pkg::q32_type  add0_in, add1_in;
   logic               shift_hi_in;
   logic signed [65:0] mul_full;
   logic signed [63:0] rnd_lo, rnd_hi, rnd, sum_in, sat_in;
   logic               sat_flag;

   assign dt_op = {9'b0, dt_ff};

   // operand selection per step
   always_comb begin
      op_a_in     = '0;
      op_b_in     = '0;
      add0_in     = '0;
      add1_in     = '0;
      shift_hi_in = 1'b0;
      unique case (step_ff)
         kcvp_pkg::ST_H: begin
            op_a_in = dt_op; op_b_in = dt_op; shift_hi_in = 1'b1;
         end
         kcvp_pkg::ST_QH: begin
            op_a_in = {2'b0, accel_var_ff}; op_b_in = {h_ff[31], h_ff};
         end
         kcvp_pkg::ST_QD: begin
            op_a_in = {2'b0, accel_var_ff}; op_b_in = dt_op;
         end
         kcvp_pkg::ST_N00: begin
            op_a_in = {qh_ff[31], qh_ff}; op_b_in = {h_ff[31], h_ff};
         end
         kcvp_pkg::ST_N02: begin
            op_a_in = {qh_ff[31], qh_ff}; op_b_in = dt_op;
         end
         kcvp_pkg::ST_N22: begin
            op_a_in = {qd_ff[31], qd_ff}; op_b_in = dt_op;
         end
         kcvp_pkg::ST_A00: begin
            op_a_in = dt_op; op_b_in = {c_ff[2][31], c_ff[2]}; add0_in = c_ff[0];
         end
         kcvp_pkg::ST_A01: begin
            op_a_in = dt_op; op_b_in = {c_ff[5][31], c_ff[5]}; add0_in = c_ff[1];
         end
         kcvp_pkg::ST_A02: begin
            op_a_in = dt_op; op_b_in = {c_ff[7][31], c_ff[7]}; add0_in = c_ff[2];
         end
         kcvp_pkg::ST_A03: begin
            op_a_in = dt_op; op_b_in = {c_ff[8][31], c_ff[8]}; add0_in = c_ff[3];
         end
         kcvp_pkg::ST_A10: begin
            op_a_in = dt_op; op_b_in = {c_ff[3][31], c_ff[3]}; add0_in = c_ff[1];
         end
         kcvp_pkg::ST_A11: begin
            op_a_in = dt_op; op_b_in = {c_ff[6][31], c_ff[6]}; add0_in = c_ff[4];
         end
         kcvp_pkg::ST_A12: begin
            op_a_in = dt_op; op_b_in = {c_ff[8][31], c_ff[8]}; add0_in = c_ff[5];
         end
         kcvp_pkg::ST_A13: begin
            op_a_in = dt_op; op_b_in = {c_ff[9][31], c_ff[9]}; add0_in = c_ff[6];
         end
         kcvp_pkg::ST_P00: begin
            op_a_in = dt_op; op_b_in = {a_ff[2][31], a_ff[2]};
            add0_in = a_ff[0]; add1_in = n00_ff;
         end
         kcvp_pkg::ST_P01: begin
            op_a_in = dt_op; op_b_in = {a_ff[3][31], a_ff[3]}; add0_in = a_ff[1];
         end
         kcvp_pkg::ST_P02: begin
            add0_in = a_ff[2]; add1_in = n02_ff;
         end
         kcvp_pkg::ST_P03: begin
            add0_in = a_ff[3];
         end
         kcvp_pkg::ST_P11: begin
            op_a_in = dt_op; op_b_in = {a_ff[7][31], a_ff[7]};
            add0_in = a_ff[5]; add1_in = n00_ff;
         end
         kcvp_pkg::ST_P12: begin
            add0_in = a_ff[6];
         end
         kcvp_pkg::ST_P13: begin
            add0_in = a_ff[7]; add1_in = n02_ff;
         end
         kcvp_pkg::ST_P22: begin
            add0_in = c_ff[7]; add1_in = n22_ff;
         end
         kcvp_pkg::ST_P23: begin
            add0_in = c_ff[8];
         end
         kcvp_pkg::ST_P33: begin
            add0_in = c_ff[9]; add1_in = n22_ff;
         end
         kcvp_pkg::ST_X: begin
            op_a_in = dt_op; op_b_in = {sv_ff[2][31], sv_ff[2]}; add0_in = sv_ff[0];
         end
         kcvp_pkg::ST_Y: begin
            op_a_in = dt_op; op_b_in = {sv_ff[3][31], sv_ff[3]}; add0_in = sv_ff[1];
         end
         default: begin
            op_a_in = '0;
         end
      endcase
   end

   // shared multiplier
   assign mul_full = op_a_in * op_b_in;

   // round to nearest (ties up), add, saturate
   assign rnd_lo = (prod_ff + HALF_LO) >>> FRAC_BITS;
   assign rnd_hi = (prod_ff + HALF_HI) >>> (FRAC_BITS + 1);
   assign rnd    = shift_hi_in ? rnd_hi : rnd_lo;
   assign sum_in = rnd + {{32{add0_in[31]}}, add0_in} + {{32{add1_in[31]}}, add1_in};

   always_comb begin
      sat_flag = 1'b0;
      sat_in   = sum_in;
      if (sum_in > MAX32) begin
         sat_flag = 1'b1;
         sat_in   = MAX32;
      end else if (sum_in < MIN32) begin
         sat_flag = 1'b1;
         sat_in   = MIN32;
      end
   end

   // sequencer, state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         step_ff         <= '0;
         init_ff         <= 1'b0;
         ov_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         accel_var_ff    <= '0;
         init_pos_var_ff <= '0;
         init_vel_var_ff <= '0;
         init_vx_ff      <= INIT_V;
         init_vy_ff      <= INIT_V;
      end else begin
         // configuration writes
         if (csr_we) begin
            unique case (csr_index)
               kcvp_pkg::CSR_ACCEL_VAR:    accel_var_ff    <= csr_wdata[30:0];
               kcvp_pkg::CSR_INIT_POS_VAR: init_pos_var_ff <= csr_wdata[30:0];
               kcvp_pkg::CSR_INIT_VEL_VAR: init_vel_var_ff <= csr_wdata[30:0];
               kcvp_pkg::CSR_INIT_VX:      init_vx_ff      <= csr_wdata;
               kcvp_pkg::CSR_INIT_VY:      init_vy_ff      <= csr_wdata;
               default: ;
            endcase
         end

         // result transfer, unless the finish state reloads the register
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  dt_ff    <= req_dt;
                  ov_ff    <= 1'b0;
                  step_ff  <= kcvp_pkg::ST_H;
                  state_ff <= S_MUL;
                  if (!init_ff) begin
                     init_ff  <= 1'b1;
                     sv_ff[0] <= '0;
                     sv_ff[1] <= '0;
                     sv_ff[2] <= init_vx_ff;
                     sv_ff[3] <= init_vy_ff;
                     c_ff[0]  <= {1'b0, init_pos_var_ff};
                     c_ff[1]  <= '0;
                     c_ff[2]  <= '0;
                     c_ff[3]  <= '0;
                     c_ff[4]  <= {1'b0, init_pos_var_ff};
                     c_ff[5]  <= '0;
                     c_ff[6]  <= '0;
                     c_ff[7]  <= {1'b0, init_vel_var_ff};
                     c_ff[8]  <= '0;
                     c_ff[9]  <= {1'b0, init_vel_var_ff};
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= mul_full[63:0];
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (sat_flag) begin
                  ov_ff <= 1'b1;
               end
               unique case (step_ff)
                  kcvp_pkg::ST_H:   h_ff    <= sat_in[31:0];
                  kcvp_pkg::ST_QH:  qh_ff   <= sat_in[31:0];
                  kcvp_pkg::ST_QD:  qd_ff   <= sat_in[31:0];
                  kcvp_pkg::ST_N00: n00_ff  <= sat_in[31:0];
                  kcvp_pkg::ST_N02: n02_ff  <= sat_in[31:0];
                  kcvp_pkg::ST_N22: n22_ff  <= sat_in[31:0];
                  kcvp_pkg::ST_A00: a_ff[0] <= sat_in[31:0];
                  kcvp_pkg::ST_A01: a_ff[1] <= sat_in[31:0];
                  kcvp_pkg::ST_A02: a_ff[2] <= sat_in[31:0];
                  kcvp_pkg::ST_A03: a_ff[3] <= sat_in[31:0];
                  kcvp_pkg::ST_A10: a_ff[4] <= sat_in[31:0];
                  kcvp_pkg::ST_A11: a_ff[5] <= sat_in[31:0];
                  kcvp_pkg::ST_A12: a_ff[6] <= sat_in[31:0];
                  kcvp_pkg::ST_A13: a_ff[7] <= sat_in[31:0];
                  kcvp_pkg::ST_P00: c_ff[0] <= sat_in[31:0];
                  kcvp_pkg::ST_P01: c_ff[1] <= sat_in[31:0];
                  kcvp_pkg::ST_P02: c_ff[2] <= sat_in[31:0];
                  kcvp_pkg::ST_P03: c_ff[3] <= sat_in[31:0];
                  kcvp_pkg::ST_P11: c_ff[4] <= sat_in[31:0];
                  kcvp_pkg::ST_P12: c_ff[5] <= sat_in[31:0];
                  kcvp_pkg::ST_P13: c_ff[6] <= sat_in[31:0];
                  kcvp_pkg::ST_P22: c_ff[7] <= sat_in[31:0];
                  kcvp_pkg::ST_P23: c_ff[8] <= sat_in[31:0];
                  kcvp_pkg::ST_P33: c_ff[9] <= sat_in[31:0];
                  kcvp_pkg::ST_X:   sv_ff[0] <= sat_in[31:0];
                  kcvp_pkg::ST_Y:   sv_ff[1] <= sat_in[31:0];
                  default: ;
               endcase
               if (step_ff == kcvp_pkg::ST_LAST) begin
                  state_ff <= S_FIN;
               end else begin
                  step_ff  <= step_ff + 5'd1;
                  state_ff <= S_MUL;
               end
            end
            S_FIN: begin
               // load the output register once it is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_px_ff    <= sv_ff[0];
                  rsp_py_ff    <= sv_ff[1];
                  rsp_vx_ff    <= sv_ff[2];
                  rsp_vy_ff    <= sv_ff[3];
                  rsp_vxx_ff   <= c_ff[0];
                  rsp_cxy_ff   <= c_ff[1];
                  rsp_vyy_ff   <= c_ff[4];
                  rsp_ov_ff    <= ov_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pos_x    = rsp_px_ff;
   assign rsp_pos_y    = rsp_py_ff;
   assign rsp_vel_x    = rsp_vx_ff;
   assign rsp_vel_y    = rsp_vy_ff;
   assign rsp_var_x    = rsp_vxx_ff;
   assign rsp_cov_xy   = rsp_cxy_ff;
   assign rsp_var_y    = rsp_vyy_ff;
   assign rsp_overflow = rsp_ov_ff;

   // checks
   a_init_after_tick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> init_ff)
      else $error("initialised flag not set after a tick");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC || state_ff == S_MUL) |-> (step_ff <= kcvp_pkg::ST_LAST))
      else $error("sequencer step out of range");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("result raised outside the finish state");

   a_fin_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !rsp_stall) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("finished tick not delivered");

endmodule
`default_nettype wire
